[src/kmdg_pkg.sv]
package kmdg_pkg;

  localparam int unsigned ROW_W     = 8;
  localparam int unsigned OUT_ROW_W = 5;
  localparam int unsigned SETTLE_W  = 7;

  localparam logic [SETTLE_W-1:0] SETTLE_CAP          = 7'd100;
  localparam logic [SETTLE_W-1:0] SETTLE_TARGET_RESET = 7'd5;
  localparam logic [SETTLE_W-1:0] SETTLE_COUNT_RESET  = 7'd10;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             scan_end;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] out_row;
    logic [ROW_W-1:0]     out_bits;
    logic                 ghost_seen;
    logic                 all_released;
    logic                 report_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_GHOST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic ghost_step;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic settled;
    logic idx_first;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

[src/kmdg_ctrl.sv]
module kmdg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kmdg_pkg::sts_t   sts_i,
  output kmdg_pkg::cmd_t   cmd_o
);

  kmdg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmdg_pkg::ST_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmdg_pkg::ST_SCAN: begin
        if (in_valid_i && sts_i.settled) state_d = kmdg_pkg::ST_GHOST;
      end
      kmdg_pkg::ST_GHOST: begin
        if (sts_i.idx_first) state_d = kmdg_pkg::ST_EMIT;
      end
      kmdg_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.idx_last) state_d = kmdg_pkg::ST_SCAN;
      end
      default: state_d = kmdg_pkg::ST_SCAN;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      kmdg_pkg::ST_SCAN: begin
        in_ready_o   = 1'b1;
        cmd_o.take   = in_valid_i;
      end
      kmdg_pkg::ST_GHOST: begin
        cmd_o.ghost_step = 1'b1;
      end
      kmdg_pkg::ST_EMIT: begin
        cmd_o.emit_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[src/kmdg_datapath.sv]
module kmdg_datapath #(
  parameter int unsigned ROW_COUNT = 17,
  parameter int unsigned COL_COUNT = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kmdg_pkg::in_item_t                 in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output kmdg_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [kmdg_pkg::SETTLE_W-1:0]      cfg_data_i,
  input  kmdg_pkg::cmd_t                     cmd_i,
  output kmdg_pkg::sts_t                     sts_o
);

  localparam int unsigned IdxW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned PosW    = $clog2(ROW_COUNT + 1);
  localparam int unsigned ColW    = COL_COUNT;
  localparam int unsigned RowW    = kmdg_pkg::ROW_W;
  localparam int unsigned OutRowW = kmdg_pkg::OUT_ROW_W;
  localparam int unsigned SetW    = kmdg_pkg::SETTLE_W;
  localparam logic [PosW-1:0] PosLimit = PosW'(ROW_COUNT);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(ROW_COUNT - 1);

  logic [ColW-1:0] live_q [ROW_COUNT];
  logic [ColW-1:0] rep_q  [ROW_COUNT];

  logic [PosW-1:0] pos_q;
  logic [IdxW-1:0] idx_q;
  logic [SetW-1:0] cnt_q, cnt_d;
  logic [SetW-1:0] target_q;
  logic            changed_q;
  logic            ghost_q, ghost_d;
  logic [ColW-1:0] below_q, below_d;
  logic [ColW-1:0] or_q, or_d;
  logic            any_q;
  logic            out_valid_q;
  kmdg_pkg::out_item_t out_q;

  logic [ColW-1:0] bits;
  logic            pos_ok;
  logic [IdxW-1:0] rd_idx;
  logic [ColW-1:0] rd_row;
  logic            row_diff;
  logic            changed_any;
  logic [ColW-1:0] upper;

  assign bits   = in_data_i.row_bits[ColW-1:0];
  assign pos_ok = pos_q < PosLimit;
  assign rd_idx = cmd_i.ghost_step ? idx_q : pos_q[IdxW-1:0];
  assign rd_row = live_q[rd_idx];

  assign row_diff    = pos_ok && (rd_row != bits);
  assign changed_any = changed_q || row_diff;

  always_comb begin
    if (changed_any) begin
      cnt_d = '0;
    end else if (cnt_q < kmdg_pkg::SETTLE_CAP) begin
      cnt_d = cnt_q + SetW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign upper   = rd_row & (rd_row - ColW'(1));
  assign ghost_d = ghost_q || ((upper & below_q) != '0);
  assign below_d = below_q | rd_row;
  assign or_d    = or_q | rd_row;

  assign sts_o.settled   = in_data_i.scan_end && (cnt_d == target_q);
  assign sts_o.idx_first = (idx_q == '0);
  assign sts_o.idx_last  = (idx_q == IdxLast);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= kmdg_pkg::SETTLE_TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        live_q[r] <= '0;
      end
      pos_q     <= '0;
      cnt_q     <= kmdg_pkg::SETTLE_COUNT_RESET;
      changed_q <= 1'b0;
    end else if (cmd_i.take) begin
      if (row_diff) begin
        live_q[pos_q[IdxW-1:0]] <= bits;
      end
      if (in_data_i.scan_end) begin
        cnt_q     <= cnt_d;
        changed_q <= 1'b0;
        pos_q     <= '0;
      end else begin
        changed_q <= changed_any;
        if (pos_ok) begin
          pos_q <= pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        rep_q[r] <= '0;
      end
      idx_q   <= '0;
      ghost_q <= 1'b0;
      below_q <= '0;
      or_q    <= '0;
      any_q   <= 1'b0;
    end else begin
      if (cmd_i.take && sts_o.settled) begin
        idx_q   <= IdxLast;
        ghost_q <= 1'b0;
        below_q <= '0;
        or_q    <= '0;
      end else if (cmd_i.ghost_step) begin
        ghost_q <= ghost_d;
        below_q <= below_d;
        or_q    <= or_d;
        if (sts_o.idx_first) begin
          if (!ghost_d) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
              rep_q[r] <= live_q[r];
            end
            any_q <= (or_d != '0);
          end
        end else begin
          idx_q <= idx_q - IdxW'(1);
        end
      end else if (cmd_i.emit_load) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q.out_row      <= OutRowW'(idx_q);
      out_q.out_bits     <= RowW'(rep_q[idx_q]);
      out_q.ghost_seen   <= ghost_q;
      out_q.all_released <= !any_q;
      out_q.report_last  <= sts_o.idx_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/key_matrix_debounce_ghost_filter.sv]
// Rows are taken one per cycle while scanning; the scan-end row of a settled
// scan starts a ghost pass over the stored rows (one stored row per cycle,
// last row first) and then a report burst of ROW_COUNT results, one per cycle
// when the sink is ready. Input is held off during that pass and burst.
// Reset: matrices zero, settle count 10, settle target 5, no result pending.
module key_matrix_debounce_ghost_filter #(
  parameter int unsigned ROW_COUNT = 17,
  parameter int unsigned COL_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kmdg_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kmdg_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [kmdg_pkg::SETTLE_W-1:0] cfg_data_i
);

  kmdg_pkg::cmd_t cmd;
  kmdg_pkg::sts_t sts;

  kmdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmdg_datapath #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[test/tb.sv]
module tb;

  localparam int unsigned ROWS      = 17;
  localparam int unsigned COLS      = 8;
  localparam int unsigned SETTLE_PAD = 60;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned ROW_W     = kmdg_pkg::ROW_W;
  localparam int unsigned SETTLE_W  = kmdg_pkg::SETTLE_W;
  localparam int unsigned OUT_ROW_W = kmdg_pkg::OUT_ROW_W;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  kmdg_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  kmdg_pkg::out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [SETTLE_W-1:0] cfg_data_i  = '0;

  key_matrix_debounce_ghost_filter #(
    .ROW_COUNT(ROWS),
    .COL_COUNT(COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  kmdg_pkg::in_item_t  row_q[$];
  kmdg_pkg::out_item_t report_q[$];
  int                  err_cnt = 0;

  logic [ROW_W-1:0]    live_m [ROWS];
  logic [ROW_W-1:0]    shown_m[ROWS];
  logic [SETTLE_W-1:0] settle_cnt;
  logic [SETTLE_W-1:0] settle_tgt;
  logic                scan_dirty;
  int unsigned         row_pos;

  logic in_taken = 1'b0;
  bit   hold_go  = 1'b0;
  bit   hold_done = 1'b0;

  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic model_row(input kmdg_pkg::in_item_t it);
    logic [ROW_W-1:0]    bits;
    logic [ROW_W-1:0]    below;
    logic [ROW_W-1:0]    upper;
    logic                ghost;
    logic                released;
    kmdg_pkg::out_item_t o;
    int                  r;
    bits = it.row_bits & ROW_W'((1 << COLS) - 1);
    if (row_pos < ROWS) begin
      if (live_m[row_pos] != bits) begin
        live_m[row_pos] = bits;
        scan_dirty = 1'b1;
      end
      row_pos++;
    end
    if (it.scan_end) begin
      if (scan_dirty) settle_cnt = '0;
      else if (settle_cnt < kmdg_pkg::SETTLE_CAP) settle_cnt = settle_cnt + 1'b1;
      scan_dirty = 1'b0;
      row_pos = 0;
      if (settle_cnt == settle_tgt) begin
        ghost = 1'b0;
        below = '0;
        for (r = ROWS - 1; r >= 0; r--) begin
          upper = live_m[r] & (live_m[r] - 1'b1);
          if ((upper & below) != '0) ghost = 1'b1;
          below = below | live_m[r];
        end
        if (!ghost) begin
          for (r = 0; r < ROWS; r++) shown_m[r] = live_m[r];
        end
        released = 1'b1;
        for (r = 0; r < ROWS; r++) begin
          if (shown_m[r] != '0) released = 1'b0;
        end
        for (r = 0; r < ROWS; r++) begin
          o.out_row      = OUT_ROW_W'(r);
          o.out_bits     = shown_m[r];
          o.ghost_seen   = ghost;
          o.all_released = released;
          o.report_last  = (r == ROWS - 1);
          report_q.push_back(o);
        end
      end
    end
  endtask

  task automatic check_result(input kmdg_pkg::out_item_t got);
    kmdg_pkg::out_item_t want;
    if (report_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result row %0d bits %h", got.out_row, got.out_bits));
    end else begin
      want = report_q.pop_front();
      if (got.out_row !== want.out_row)
        note_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
      if (got.out_bits !== want.out_bits)
        note_mismatch($sformatf("row %0d out_bits %h, want %h",
                                want.out_row, got.out_bits, want.out_bits));
      if (got.ghost_seen !== want.ghost_seen)
        note_mismatch($sformatf("row %0d ghost_seen %b, want %b",
                                want.out_row, got.ghost_seen, want.ghost_seen));
      if (got.all_released !== want.all_released)
        note_mismatch($sformatf("row %0d all_released %b, want %b",
                                want.out_row, got.all_released, want.all_released));
      if (got.report_last !== want.report_last)
        note_mismatch($sformatf("row %0d report_last %b, want %b",
                                want.out_row, got.report_last, want.report_last));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        live_m[r]  = '0;
        shown_m[r] = '0;
      end
      settle_cnt = kmdg_pkg::SETTLE_COUNT_RESET;
      settle_tgt = kmdg_pkg::SETTLE_TARGET_RESET;
      scan_dirty = 1'b0;
      row_pos    = 0;
      in_taken  <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (cfg_we_i) settle_tgt = cfg_data_i;
      if (in_valid_i && in_ready_o) model_row(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (row_q.size() != 0) begin
        in_data_i  <= row_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  int mode      = 0;
  int mode_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  logic [ROW_W-1:0] scan_img[20];
  int               scan_len = ROWS;

  function automatic logic [ROW_W-1:0] rand_row();
    case ($urandom_range(0, 3))
      0: rand_row = '0;
      1: rand_row = ROW_W'(1) << $urandom_range(0, ROW_W - 1);
      2: rand_row = (ROW_W'(1) << $urandom_range(0, ROW_W - 1)) |
                    (ROW_W'(1) << $urandom_range(0, ROW_W - 1));
      default: rand_row = ROW_W'($urandom);
    endcase
  endfunction

  task automatic push_row(input logic [ROW_W-1:0] bits, input logic last);
    kmdg_pkg::in_item_t it;
    it.row_bits = bits;
    it.scan_end = last;
    row_q.push_back(it);
  endtask

  task automatic push_scan();
    for (int i = 0; i < scan_len; i++) push_row(scan_img[i], i == scan_len - 1);
  endtask

  task automatic random_phase(input int n);
    int cnt;
    int kind;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) scan_len = ROWS;
      else if (kind < 8) scan_len = $urandom_range(1, 4);
      else if (kind == 8) scan_len = $urandom_range(ROWS + 1, ROWS + 3);
      if (kind != 9) begin
        for (int i = 0; i < scan_len; i++) scan_img[i] = rand_row();
      end
      push_scan();
      cnt += scan_len;
      if ($urandom_range(0, 1) == 1) begin
        push_scan();
        cnt += scan_len;
      end
    end
  endtask

  task automatic wait_idle();
    while (row_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_PAD) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [SETTLE_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 20; i++) scan_img[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-row scans settle under the reset target
    push_row(8'hFF, 1'b1);
    repeat (5) push_row(8'hFF, 1'b1);
    wait_idle();

    write_target(7'd0);
    // ghost on a short scan, then an over-long all-released scan
    push_row(8'h03, 1'b0);
    push_row(8'h02, 1'b1);
    for (int i = 0; i < ROWS; i++) push_row(8'h00, 1'b0);
    push_row(8'hFF, 1'b1);
    random_phase(15);
    wait_idle();

    write_target(7'd1);
    hold_go = 1'b1;
    // changed scan then a repeat: settles while the sink holds off
    push_row(8'h11, 1'b0);
    push_row(8'h00, 1'b1);
    push_row(8'h22, 1'b0);
    push_row(8'h00, 1'b1);
    push_row(8'h22, 1'b0);
    push_row(8'h00, 1'b1);
    random_phase(20);
    wait_idle();

    write_target(7'd127);
    random_phase(10);
    wait_idle();

    write_target(7'd2);
    random_phase(15);
    wait_idle();

    if (report_q.size() != 0) note_mismatch("expected results left over");
    if (err_cnt == 0) begin
      $display("** key_matrix_debounce_ghost_filter: PASSED **");
    end else begin
      $display("** key_matrix_debounce_ghost_filter: FAILED **");
    end
    $finish;
  end

  initial begin
    for (int n = 0; n < LIMIT; n++) @(posedge clk_i);
    $display("** key_matrix_debounce_ghost_filter: FAILED **");
    $finish;
  end

endmodule

[key_matrix_debounce_ghost_filter.f]
src/kmdg_pkg.sv
src/kmdg_ctrl.sv
src/kmdg_datapath.sv
src/key_matrix_debounce_ghost_filter.sv
test/tb.sv
